@@ src/tdt_pkg.sv @@
package tdt_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = SLOT_W + 1;
    localparam int DL_W   = 63;
    localparam int PER_W  = 40;
    localparam int SEQ_W  = 32;
    localparam int PS_W   = SEQ_W + PER_W;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_MISS      = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CANCEL,
        ST_DUE,
        ST_PICK,
        ST_EXPIRE,
        ST_REMAIN,
        ST_DONE
    } state_t;

endpackage

@@ src/tdt_ram.sv @@
module tdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/timer_deadline_table_top.sv @@
// Timer table of SLOTS slots held in two RAMs with registered read data, with
// the armed and repeating flags in flip-flops. A word is taken when start is
// high and busy is low; results appear one per cycle-strobe on valid and
// cannot be held off. An add answers straight from the idle state; a cancel
// first makes one RAM read and answers from ST_CANCEL. A tick makes one pass
// over the RAM to mark due slots, then one pass per expiry to find the
// earliest due slot plus a last pass that finds none, then a final pass for
// the earliest remaining deadline. The passes run one after another through
// the shared RAM read address.
module timer_deadline_table_top
    import tdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [62:0] when_us,
    input  logic [39:0] interval_us,
    input  logic [3:0]  cancel_slot,
    input  logic [31:0] cancel_seq,
    input  logic [62:0] now_us,
    output logic        valid,
    output logic [2:0]  kind,
    output logic [3:0]  slot,
    output logic [31:0] seq,
    output logic [62:0] deadline_us,
    output logic        next_valid,
    output logic        last
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rdv_reg, rdv_next;
    logic [SLOT_W-1:0] rdidx_reg, rdidx_next;
    logic [SLOTS-1:0]  armed_reg, armed_next;
    logic [SLOTS-1:0]  rep_reg, rep_next;
    logic [SLOTS-1:0]  due_reg, due_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] bidx_reg, bidx_next;
    logic [DL_W-1:0]   bdl_reg, bdl_next;
    logic [SEQ_W-1:0]  bseq_reg, bseq_next;
    logic [PER_W-1:0]  bper_reg, bper_next;
    logic [DL_W-1:0]   now_reg, now_next;
    logic [3:0]        cs_reg, cs_next;
    logic [SEQ_W-1:0]  cq_reg, cq_next;
    logic              csok_reg, csok_next;
    logic [SEQ_W-1:0]  nseq_reg, nseq_next;

    logic              valid_reg, valid_next;
    logic [2:0]        kind_reg, kind_next;
    logic [3:0]        slot_reg, slot_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [DL_W-1:0]   dl_reg, dl_next;
    logic              last_reg, last_next;
    logic              nv_reg;

    logic              dl_we, ps_we;
    logic [SLOT_W-1:0] waddr, raddr;
    logic [DL_W-1:0]   dl_wdata, rd_dl;
    logic [PS_W-1:0]   ps_wdata, rd_ps;

    logic              have_free;
    logic [SLOT_W-1:0] free_idx;
    logic [DL_W:0]     rearm_sum;

    tdt_ram #(.WIDTH(DL_W), .DEPTH(SLOTS)) u_dl_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (waddr),
        .wdata (dl_wdata),
        .raddr (raddr),
        .rdata (rd_dl)
    );

    tdt_ram #(.WIDTH(PS_W), .DEPTH(SLOTS)) u_ps_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (waddr),
        .wdata (ps_wdata),
        .raddr (raddr),
        .rdata (rd_ps)
    );

    // Lowest free slot; the loop walks down so the lowest index wins.
    always_comb
    begin
        have_free = 1'b0;
        free_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!armed_reg[i])
            begin
                have_free = 1'b1;
                free_idx  = SLOT_W'(i);
            end
        end
    end

    assign rearm_sum = {1'b0, now_reg} + {{(DL_W + 1 - PER_W){1'b0}}, bper_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rdv_next   = 1'b0;
        rdidx_next = rdidx_reg;
        armed_next = armed_reg;
        rep_next   = rep_reg;
        due_next   = due_reg;
        found_next = found_reg;
        bidx_next  = bidx_reg;
        bdl_next   = bdl_reg;
        bseq_next  = bseq_reg;
        bper_next  = bper_reg;
        now_next   = now_reg;
        cs_next    = cs_reg;
        cq_next    = cq_reg;
        csok_next  = csok_reg;
        nseq_next  = nseq_reg;
        valid_next = 1'b0;
        kind_next  = kind_reg;
        slot_next  = slot_reg;
        seq_next   = seq_reg;
        dl_next    = dl_reg;
        last_next  = 1'b0;
        dl_we      = 1'b0;
        ps_we      = 1'b0;
        waddr      = free_idx;
        dl_wdata   = when_us;
        ps_wdata   = {nseq_reg, interval_us};
        raddr      = cnt_reg[SLOT_W-1:0];

        // Shared scan: issue one read a cycle, data comes back in the next cycle.
        if (state_reg == ST_DUE || state_reg == ST_PICK || state_reg == ST_REMAIN)
        begin
            if (cnt_reg < CNT_W'(SLOTS))
            begin
                rdv_next   = 1'b1;
                rdidx_next = cnt_reg[SLOT_W-1:0];
                cnt_next   = cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                raddr = SLOT_W'(cancel_slot);
                if (start)
                begin
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            dl_next    = '0;
                            if (have_free)
                            begin
                                dl_we               = 1'b1;
                                ps_we               = 1'b1;
                                armed_next[free_idx] = 1'b1;
                                rep_next[free_idx]   = (interval_us != '0);
                                kind_next           = KIND_ADDED;
                                slot_next           = 4'(free_idx);
                                seq_next            = nseq_reg;
                                nseq_next           = nseq_reg + 1'b1;
                            end
                            else
                            begin
                                kind_next = KIND_FULL;
                                slot_next = '0;
                                seq_next  = '0;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            cs_next    = cancel_slot;
                            cq_next    = cancel_seq;
                            csok_next  = (32'(cancel_slot) < SLOTS);
                            state_next = ST_CANCEL;
                        end
                        CMD_TICK:
                        begin
                            now_next   = now_us;
                            cnt_next   = '0;
                            due_next   = '0;
                            state_next = ST_DUE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CANCEL:
            begin
                valid_next = 1'b1;
                last_next  = 1'b1;
                slot_next  = cs_reg;
                seq_next   = cq_reg;
                dl_next    = '0;
                if (csok_reg && armed_reg[SLOT_W'(cs_reg)]
                    && rd_ps[PS_W-1:PER_W] == cq_reg)
                begin
                    armed_next[SLOT_W'(cs_reg)] = 1'b0;
                    kind_next = KIND_CANCELLED;
                end
                else
                begin
                    kind_next = KIND_MISS;
                end
                state_next = ST_IDLE;
            end
            ST_DUE:
            begin
                if (rdv_reg)
                begin
                    due_next[rdidx_reg] = armed_reg[rdidx_reg] && (rd_dl <= now_reg);
                end
                if (cnt_reg == CNT_W'(SLOTS) && !rdv_reg)
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (rdv_reg && due_reg[rdidx_reg] && (!found_reg || rd_dl < bdl_reg))
                begin
                    found_next = 1'b1;
                    bidx_next  = rdidx_reg;
                    bdl_next   = rd_dl;
                    bseq_next  = rd_ps[PS_W-1:PER_W];
                    bper_next  = rd_ps[PER_W-1:0];
                end
                if (cnt_reg == CNT_W'(SLOTS) && !rdv_reg)
                begin
                    cnt_next   = '0;
                    state_next = found_reg ? ST_EXPIRE : ST_REMAIN;
                    found_next = 1'b0;
                end
            end
            ST_EXPIRE:
            begin
                valid_next          = 1'b1;
                kind_next           = KIND_EXPIRED;
                slot_next           = 4'(bidx_reg);
                seq_next            = bseq_reg;
                dl_next             = bdl_reg;
                due_next[bidx_reg]  = 1'b0;
                waddr               = bidx_reg;
                // Re-arm saturates at the largest representable deadline.
                dl_wdata            = rearm_sum[DL_W] ? {DL_W{1'b1}} : rearm_sum[DL_W-1:0];
                if (bper_reg != '0)
                begin
                    dl_we = 1'b1;
                end
                else
                begin
                    armed_next[bidx_reg] = 1'b0;
                end
                cnt_next   = '0;
                found_next = 1'b0;
                state_next = ST_PICK;
            end
            ST_REMAIN:
            begin
                if (rdv_reg && armed_reg[rdidx_reg] && (!found_reg || rd_dl < bdl_reg))
                begin
                    found_next = 1'b1;
                    bdl_next   = rd_dl;
                end
                if (cnt_reg == CNT_W'(SLOTS) && !rdv_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                valid_next = 1'b1;
                last_next  = 1'b1;
                kind_next  = KIND_TICK_DONE;
                slot_next  = '0;
                seq_next   = '0;
                dl_next    = found_reg ? bdl_reg : '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rdv_reg   <= 1'b0;
            armed_reg <= '0;
            rep_reg   <= '0;
            due_reg   <= '0;
            found_reg <= 1'b0;
            nseq_reg  <= SEQ_W'(1);
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            nv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rdv_reg   <= rdv_next;
            armed_reg <= armed_next;
            rep_reg   <= rep_next;
            due_reg   <= due_next;
            found_reg <= found_next;
            nseq_reg  <= nseq_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            // Due one-shot slots still to be reported will be freed, so they
            // already count as gone.
            nv_reg    <= |(armed_next & ~(due_next & ~rep_next));
        end
    end

    always_ff @(posedge clk)
    begin
        rdidx_reg <= rdidx_next;
        bidx_reg  <= bidx_next;
        bdl_reg   <= bdl_next;
        bseq_reg  <= bseq_next;
        bper_reg  <= bper_next;
        now_reg   <= now_next;
        cs_reg    <= cs_next;
        cq_reg    <= cq_next;
        csok_reg  <= csok_next;
        kind_reg  <= kind_next;
        slot_reg  <= slot_next;
        seq_reg   <= seq_next;
        dl_reg    <= dl_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign valid       = valid_reg;
    assign kind        = kind_reg;
    assign slot        = slot_reg;
    assign seq         = seq_reg;
    assign deadline_us = dl_reg;
    assign next_valid  = nv_reg;
    assign last        = last_reg;

endmodule

@@ tb/timer_deadline_table_top_tb.sv @@
module timer_deadline_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tdt_pkg::*;

    localparam logic [62:0] MAX_TIME = {63{1'b1}};
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] seq;
        logic [62:0] deadline_us;
        logic        next_valid;
        logic        last;
    } timer_event_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [62:0] when_us;
        logic [39:0] interval_us;
        logic [3:0]  cancel_slot;
        logic [31:0] cancel_seq;
        logic [62:0] now_us;
        bit          has_typed;
        logic [2:0]  typed_kind;
        logic [3:0]  typed_slot;
        logic [31:0] typed_seq;
    } timer_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = CMD_ADD;
    logic [62:0] when_us = '0;
    logic [39:0] interval_us = '0;
    logic [3:0]  cancel_slot = '0;
    logic [31:0] cancel_seq = '0;
    logic [62:0] now_us = '0;
    logic        valid;
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] seq;
    logic [62:0] deadline_us;
    logic        next_valid;
    logic        last;

    // Predictor copy of the slot table.
    bit          tbl_armed [SLOTS];
    logic [62:0] tbl_deadline [SLOTS];
    logic [39:0] tbl_period [SLOTS];
    logic [31:0] tbl_seq [SLOTS];
    logic [31:0] tbl_next_seq;

    timer_event_t pending_events[$];
    timer_word_t  directed[$];
    int error_count = 0;
    int words_sent = 0;
    int events_seen = 0;
    int expiries_seen = 0;
    int cycle_count = 0;

    timer_deadline_table_top DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timer_deadline_table_top_tb: FAIL");
            $finish;
        end
    end

    function automatic timer_event_t make_event(logic [2:0] k, logic [3:0] s,
                                                logic [31:0] q, logic [62:0] d);
        timer_event_t e;
        e = '0;
        e.kind = k;
        e.slot = s;
        e.seq = q;
        e.deadline_us = d;
        return e;
    endfunction

    // Applies one word to the table copy and queues the results it causes.
    task automatic predict_timer_word(input timer_word_t w);
        timer_event_t evs[$];
        bit due [SLOTS];
        bit found;
        bit any;
        int pick;
        int free_slot;
        logic [62:0] best;
        logic [63:0] sum;
        free_slot = -1;
        found = 0;
        best = '0;
        if (w.cmd == CMD_ADD)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (!tbl_armed[i] && free_slot < 0) free_slot = i;
            if (free_slot < 0)
                evs.push_back(make_event(KIND_FULL, 0, 0, 0));
            else
            begin
                tbl_armed[free_slot] = 1;
                tbl_deadline[free_slot] = w.when_us;
                tbl_period[free_slot] = w.interval_us;
                tbl_seq[free_slot] = tbl_next_seq;
                evs.push_back(make_event(KIND_ADDED, 4'(free_slot), tbl_next_seq, 0));
                tbl_next_seq = tbl_next_seq + 1;
            end
        end
        else if (w.cmd == CMD_CANCEL)
        begin
            if (tbl_armed[w.cancel_slot] && tbl_seq[w.cancel_slot] == w.cancel_seq)
            begin
                tbl_armed[w.cancel_slot] = 0;
                evs.push_back(make_event(KIND_CANCELLED, w.cancel_slot, w.cancel_seq, 0));
            end
            else
                evs.push_back(make_event(KIND_MISS, w.cancel_slot, w.cancel_seq, 0));
        end
        else if (w.cmd == CMD_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
                due[i] = tbl_armed[i] && tbl_deadline[i] <= w.now_us;
            forever
            begin
                pick = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (due[i] && (pick < 0 || tbl_deadline[i] < tbl_deadline[pick]))
                        pick = i;
                if (pick < 0) break;
                due[pick] = 0;
                evs.push_back(make_event(KIND_EXPIRED, 4'(pick), tbl_seq[pick],
                                         tbl_deadline[pick]));
                if (tbl_period[pick] != 0)
                begin
                    sum = {1'b0, w.now_us} + {24'd0, tbl_period[pick]};
                    tbl_deadline[pick] = sum[63] ? MAX_TIME : sum[62:0];
                end
                else
                    tbl_armed[pick] = 0;
            end
            for (int i = 0; i < SLOTS; i++)
                if (tbl_armed[i] && (!found || tbl_deadline[i] < best))
                begin
                    best = tbl_deadline[i];
                    found = 1;
                end
            evs.push_back(make_event(KIND_TICK_DONE, 0, 0, found ? best : '0));
        end
        any = 0;
        for (int i = 0; i < SLOTS; i++) any |= tbl_armed[i];
        foreach (evs[k])
        begin
            evs[k].next_valid = any;
            evs[k].last = (k == evs.size() - 1);
            pending_events.push_back(evs[k]);
        end
    endtask

    // Results are sampled at the edge that ends their cycle.
    always @(posedge clk)
    begin
        timer_event_t exp_ev;
        if (rst_n && valid)
        begin
            events_seen++;
            if (kind == KIND_EXPIRED) expiries_seen++;
            if (pending_events.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d", kind, slot);
                error_count++;
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (kind !== exp_ev.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_ev.kind, kind);
                    error_count++;
                end
                if (slot !== exp_ev.slot)
                begin
                    $error("slot: expected %0d, got %0d", exp_ev.slot, slot);
                    error_count++;
                end
                if (seq !== exp_ev.seq)
                begin
                    $error("seq: expected %0d, got %0d", exp_ev.seq, seq);
                    error_count++;
                end
                if (deadline_us !== exp_ev.deadline_us)
                begin
                    $error("deadline_us: expected %0d, got %0d",
                           exp_ev.deadline_us, deadline_us);
                    error_count++;
                end
                if (next_valid !== exp_ev.next_valid)
                begin
                    $error("next_valid: expected %0d, got %0d",
                           exp_ev.next_valid, next_valid);
                    error_count++;
                end
                if (last !== exp_ev.last)
                begin
                    $error("last: expected %0d, got %0d", exp_ev.last, last);
                    error_count++;
                end
            end
        end
    end

    function automatic timer_word_t word_of(logic [1:0] c, logic [62:0] w,
                                            logic [39:0] p, logic [3:0] cs,
                                            logic [31:0] cq, logic [62:0] n);
        timer_word_t t;
        t.cmd = c;
        t.when_us = w;
        t.interval_us = p;
        t.cancel_slot = cs;
        t.cancel_seq = cq;
        t.now_us = n;
        t.has_typed = 0;
        t.typed_kind = '0;
        t.typed_slot = '0;
        t.typed_seq = '0;
        return t;
    endfunction

    function automatic timer_word_t typed(timer_word_t t, logic [2:0] k,
                                          logic [3:0] s, logic [31:0] q);
        t.has_typed = 1;
        t.typed_kind = k;
        t.typed_slot = s;
        t.typed_seq = q;
        return t;
    endfunction

    // Sends one word, honouring busy, after an optional gap. Start stays high
    // between words sent back to back and is dropped only for a gap.
    task automatic send_word(input timer_word_t w, input int gap);
        int depth;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= w.cmd;
        when_us <= w.when_us;
        interval_us <= w.interval_us;
        cancel_slot <= w.cancel_slot;
        cancel_seq <= w.cancel_seq;
        now_us <= w.now_us;
        @(posedge clk);
        while (busy) @(posedge clk);
        depth = pending_events.size();
        predict_timer_word(w);
        words_sent++;
        // A directed row with a typed answer is cross-checked against the predictor.
        if (w.has_typed && pending_events.size() > depth)
        begin
            if (pending_events[depth].kind !== w.typed_kind ||
                pending_events[depth].slot !== w.typed_slot ||
                pending_events[depth].seq !== w.typed_seq)
            begin
                $error("directed row: expected kind %0d slot %0d seq %0d",
                       w.typed_kind, w.typed_slot, w.typed_seq);
                error_count++;
            end
        end
    endtask

    function automatic logic [62:0] rand63();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [62:0] rand_time(logic [62:0] base);
        case ($urandom_range(0, 9))
            0: return rand63();
            1: return MAX_TIME - $urandom_range(0, 3);
            2: return '0;
            default: return base + $urandom_range(0, 400);
        endcase
    endfunction

    function automatic logic [39:0] rand_period();
        case ($urandom_range(0, 7))
            0, 1, 2: return '0;
            3: return {$urandom, $urandom};
            4: return {40{1'b1}};
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    initial
    begin
        logic [62:0] clock_now;
        int burst;
        int pick;
        int n_rand;
        int live [$];
        clock_now = 1000;
        tbl_next_seq = 1;
        foreach (tbl_armed[i])
        begin
            tbl_armed[i] = 0;
            tbl_deadline[i] = '0;
            tbl_period[i] = '0;
            tbl_seq[i] = '0;
        end

        // Directed rows: empty tick, extremes, fill to full, misses, a hit cancel, saturated re-arm, unknown command.
        directed.push_back(word_of(CMD_TICK, 0, 0, 0, 0, MAX_TIME));
        directed.push_back(typed(word_of(CMD_ADD, MAX_TIME, {40{1'b1}}, 0, 0, 0),
                                 KIND_ADDED, 0, 1));
        directed.push_back(typed(word_of(CMD_ADD, 0, 0, 0, 0, 0), KIND_ADDED, 1, 2));
        for (int i = 2; i < SLOTS; i++)
            directed.push_back(word_of(CMD_ADD, 50 + (i % 3), i % 2, 0, 0, 0));
        directed.push_back(typed(word_of(CMD_ADD, 5, 5, 0, 0, 0), KIND_FULL, 0, 0));
        directed.push_back(typed(word_of(CMD_CANCEL, 0, 0, 4'hF, 32'hFFFF_FFFF, 0),
                                 KIND_MISS, 4'hF, 32'hFFFF_FFFF));
        directed.push_back(typed(word_of(CMD_CANCEL, 0, 0, 1, 2, 0),
                                 KIND_CANCELLED, 1, 2));
        directed.push_back(word_of(CMD_TICK, 0, 0, 0, 0, 60));
        directed.push_back(word_of(CMD_TICK, 0, 0, 0, 0, MAX_TIME));
        directed.push_back(word_of(2'd3, MAX_TIME, {40{1'b1}}, 4'hF, '1, MAX_TIME));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[i])
            send_word(directed[i], $urandom_range(0, 2));

        // Clear the table so the random part starts from a known shape.
        for (int i = 0; i < SLOTS; i++)
            if (tbl_armed[i])
                send_word(word_of(CMD_CANCEL, 0, 0, i, tbl_seq[i], 0), 0);

        n_rand = 0;
        while (n_rand < 440)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                live.delete();
                for (int i = 0; i < SLOTS; i++) if (tbl_armed[i]) live.push_back(i);
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_word(word_of(CMD_ADD, rand_time(clock_now), rand_period(),
                                      0, 0, 0), 0);
                else if (pick < 60)
                begin
                    if (live.size() > 0 && $urandom_range(0, 3) != 0)
                    begin
                        pick = live[$urandom_range(0, live.size() - 1)];
                        send_word(word_of(CMD_CANCEL, 0, 0, pick,
                                          tbl_seq[pick] ^ ($urandom_range(0, 5) == 0),
                                          0), 0);
                    end
                    else
                        send_word(word_of(CMD_CANCEL, 0, 0, $urandom, $urandom, 0), 0);
                end
                else if (pick < 97)
                begin
                    clock_now = clock_now + $urandom_range(0, 200);
                    send_word(word_of(CMD_TICK, 0, 0, 0, 0,
                                      ($urandom_range(0, 19) == 0) ? MAX_TIME
                                                                    : clock_now), 0);
                end
                else
                    send_word(word_of(2'd3, rand63(), $urandom, $urandom, $urandom,
                                      rand63()), 0);
                n_rand++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end

        start <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (4 * SLOTS + 20) @(posedge clk);

        $display("Sent %0d words; checked %0d results, %0d of them expiries.",
                 words_sent, events_seen, expiries_seen);
        if (error_count == 0)
            $display("timer_deadline_table_top_tb: PASS");
        else
            $display("timer_deadline_table_top_tb: FAIL");
        $finish;
    end
endmodule
